// ----- src/aes_pkg.sv -----
// Package: AES-128 types, register codes, S-box tables and round functions.
package aes_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned NUM_ROUNDS  = 10;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;

  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_t;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] xt(input logic [7:0] x);
    xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a state word, byte 0 in the top bits
  function automatic logic [7:0] gb(input logic [127:0] s, input int i);
    gb = s[127-8*i -: 8];
  endfunction

  // One key schedule step: next round key from the current one
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t  = {FWD_SBOX[k[23:16]], FWD_SBOX[k[15:8]], FWD_SBOX[k[7:0]], FWD_SBOX[k[31:24]]};
    t  = t ^ {rc, 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    key_step = {w0, w1, w2, w3};
  endfunction

  // Forward round: sub bytes, shift rows, optional mix columns, add key
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = FWD_SBOX[gb(s, 4*((c+r)%4)+r)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        m[4*c+r] = xt(t[4*c+r]) ^ xt(t[4*c+(r+1)%4]) ^ t[4*c+(r+1)%4]
                 ^ t[4*c+(r+2)%4] ^ t[4*c+(r+3)%4];
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[127-8*i -: 8] = last ? t[i] : m[i];
    end
    enc_round = o ^ rk;
  endfunction

  // Inverse round: inverse shift rows, inverse sub bytes, add key, optional inverse mix
  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0] t [16];
    logic [7:0] a [16];
    logic [7:0] x2, x4, x8;
    logic [7:0] m [16];
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*((c+r)%4)+r] = INV_SBOX[gb(s, 4*c+r)];
      end
    end
    for (int i = 0; i < 16; i++) begin
      a[i] = t[i] ^ rk[127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) begin
      m[i] = 8'h00;
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 4; k++) begin
          x2 = xt(a[4*c+(r+k)%4]);
          x4 = xt(x2);
          x8 = xt(x4);
          unique case (k)
            0:       m[4*c+r] = m[4*c+r] ^ x8 ^ x4 ^ x2;
            1:       m[4*c+r] = m[4*c+r] ^ x8 ^ x2 ^ a[4*c+(r+k)%4];
            2:       m[4*c+r] = m[4*c+r] ^ x8 ^ x4 ^ a[4*c+(r+k)%4];
            default: m[4*c+r] = m[4*c+r] ^ x8 ^ a[4*c+(r+k)%4];
          endcase
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[127-8*i -: 8] = last ? a[i] : m[i];
    end
    dec_round = o;
  endfunction

endpackage

// ----- src/aes128_block_cipher.sv -----
// Top level: AES-128 encrypt/decrypt engine with queue-style ports.
//
//  channel | handshake              | payload
//  in      | in_push / in_full      | in_data (kind, block_high, block_low)
//  out     | out_pop / out_empty    | out_data (result_high, result_low)
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One block per cycle sustained while nothing stalls; an accepted block passes the
// input queue, the key-add stage, ten round stages and the result queue write
// before out_empty goes low. After reset and after each key write, the key schedule
// sweep holds in_full high. A stalled out_pop freezes the round pipeline; the input
// queue keeps taking items until it fills.
module aes128_block_cipher import aes_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  in_t                  in_data,
  output logic                 in_full,
  input  logic                 out_pop,
  output out_t                 out_data,
  output logic                 out_empty,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);
  logic         key_busy;
  logic [127:0] rkeys [NUM_ROUNDS+1];
  logic         q_full, q_empty, q_pop;
  logic [$bits(in_t)-1:0] q_data;
  logic         r_push, r_full;
  out_t         r_data;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full || key_busy;

  aes_key #(.ROUNDS(NUM_ROUNDS)) u_key (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
    .busy(key_busy), .rkeys
  );

  // Front queue of accepted blocks
  aes_fifo #(.W($bits(in_t)), .DEPTH(QDEPTH)) u_inq (
    .clk, .rst_n,
    .push(in_push && !key_busy), .push_data(in_data), .full(q_full),
    .pop(q_pop), .pop_data(q_data), .empty(q_empty)
  );

  aes_rounds #(.ROUNDS(NUM_ROUNDS)) u_rounds (
    .clk, .rst_n, .rkeys,
    .src_valid(!q_empty), .src_data(in_t'(q_data)), .src_pop(q_pop),
    .dst_push(r_push), .dst_data(r_data), .dst_full(r_full)
  );

  // Result queue
  aes_fifo #(.W($bits(out_t)), .DEPTH(QDEPTH)) u_outq (
    .clk, .rst_n,
    .push(r_push), .push_data(r_data), .full(r_full),
    .pop(out_pop), .pop_data(out_data), .empty(out_empty)
  );

`ifndef ASSERT_OFF
  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    key_busy |-> in_full) else $error("input taken during key schedule");
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !(r_push && r_full)) else $error("result pushed into full queue");
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> key_busy) else $error("key write did not start schedule");
`endif
endmodule

// ----- src/aes_fifo.sv -----
// Small synchronous queue used as the input queue and at the result side.
module aes_fifo import aes_pkg::*; #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end
endmodule

// ----- src/aes_key.sv -----
// Key registers and round key schedule, expanded after reset and once per key write.
module aes_key import aes_pkg::*; #(
  parameter int unsigned ROUNDS = NUM_ROUNDS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  output logic                 busy,
  output logic [127:0]         rkeys [ROUNDS+1]
);
  localparam int unsigned KW = $clog2(ROUNDS + 1);

  logic [63:0]   key_hi_r, key_lo_r;
  logic          busy_r, busy_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic [127:0]  cur_r, cur_nxt;
  logic [7:0]    rc_r, rc_nxt;
  logic [127:0]  rk_r [ROUNDS+1];
  logic [127:0]  step_key;

  assign busy     = busy_r;
  assign rkeys    = rk_r;
  assign step_key = key_step(cur_r, rc_r);

  // Hold key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_KEY_HIGH) begin
        key_hi_r <= cfg_data;
      end
      if (cfg_index == REG_KEY_LOW) begin
        key_lo_r <= cfg_data;
      end
    end
  end

  // Sweep the schedule one round key a cycle
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    cur_nxt  = cur_r;
    rc_nxt   = rc_r;
    if (busy_r) begin
      if (cnt_r == '0) begin
        cur_nxt = {key_hi_r, key_lo_r};
        rc_nxt  = 8'h01;
        cnt_nxt = KW'(1);
      end else begin
        cur_nxt = step_key;
        rc_nxt  = xt(rc_r);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == KW'(ROUNDS)) begin
          busy_nxt = 1'b0;
        end
      end
    end
    if (cfg_valid) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    rc_r  <= rc_nxt;
    if (busy_r && !cfg_valid) begin
      rk_r[cnt_r] <= (cnt_r == '0) ? {key_hi_r, key_lo_r} : step_key;
    end
  end
endmodule

// ----- src/aes_rounds.sv -----
// Unrolled round pipeline: initial key add, then one round per stage.
module aes_rounds import aes_pkg::*; #(
  parameter int unsigned ROUNDS = NUM_ROUNDS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [127:0] rkeys [ROUNDS+1],
  input  logic         src_valid,
  input  in_t          src_data,
  output logic         src_pop,
  output logic         dst_push,
  output out_t         dst_data,
  input  logic         dst_full
);
  logic [127:0] st_r   [ROUNDS+1];
  logic         kind_r [ROUNDS+1];
  logic         v_r    [ROUNDS+1];
  logic [127:0] nxt    [ROUNDS+1];
  logic         adv;

  // Move only when the last stage can drain
  assign adv      = !v_r[ROUNDS] || !dst_full;
  assign src_pop  = adv && src_valid;
  assign dst_push = adv && v_r[ROUNDS];
  assign dst_data = out_t'(st_r[ROUNDS]);

  assign nxt[0] = {src_data.block_high, src_data.block_low}
                ^ ((src_data.kind == KIND_DEC) ? rkeys[ROUNDS] : rkeys[0]);

  for (genvar i = 1; i <= ROUNDS; i++) begin : g_stage
    assign nxt[i] = (kind_r[i-1] == KIND_DEC)
                  ? dec_round(st_r[i-1], rkeys[ROUNDS-i], i == ROUNDS)
                  : enc_round(st_r[i-1], rkeys[i], i == ROUNDS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= ROUNDS; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (adv) begin
      v_r[0] <= src_valid;
      for (int i = 1; i <= ROUNDS; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0]   <= nxt[0];
      kind_r[0] <= src_data.kind;
      for (int i = 1; i <= ROUNDS; i++) begin
        st_r[i]   <= nxt[i];
        kind_r[i] <= kind_r[i-1];
      end
    end
  end
endmodule
